### hdl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define CHK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/lstb_pkg.sv
// Shared types and constants for the latency statistics tracker bank.
package lstb_pkg;

  localparam int WORD_W = 64;
  localparam int ID_W   = 3;
  localparam int CMD_W  = 2;
  localparam int CFG_W  = 4;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // operation kinds after classification
  localparam logic [1:0] OP_RECORD    = 2'd0;
  localparam logic [1:0] OP_READ      = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;
  localparam logic [1:0] OP_READ_ZERO = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] sample;
  } op_t;

  typedef struct packed {
    logic div_start;
    logic div_busy;
    logic div_done;
    logic out_valid;
  } bk_status_t;

endpackage

### hdl/latency_stats_tracker_bank_top.sv
// Latency statistics tracker bank: top level.
// Input channel (push/full): one transaction carries cmd, tracker_id and
// latency_value; it is taken when push is high and full is low.
// Result channel (empty/pop): a read yields one transaction; the fields are
// valid while empty is low and leave when pop is high.
// Config channel (cfg_valid/cfg_ready): writes trackers_in_use; cfg_ready is
// always high. Write it only while the bank is idle.
// Throughput: the back end takes a record or clear from the queue head at once,
// so one sample per cycle is sustained while no read waits on the divider. A
// read with a nonzero count holds the shared 64-bit restoring divider while it
// forms 64 quotient bits and until the handoff to the result register; a read
// with count zero or an invalid id skips the quotient bits and holds it until
// the handoff. A second read stops at the head of the 4-entry command queue,
// and everything behind it, until the divider is free.
// Reset: synchronous; all trackers return to count 0, sum 0, min all ones,
// max 0, trackers_in_use to 0, command queue and result register empty.
// Stall: a result not popped holds the divider's finished quotient; once
// the queue fills, full rises and input transactions wait.
`include "assert_macros.svh"

module latency_stats_tracker_bank_top #(
  parameter int NUM_TRACKERS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [lstb_pkg::CMD_W-1:0]  cmd,
  input  logic [lstb_pkg::ID_W-1:0]   tracker_id,
  input  logic [lstb_pkg::WORD_W-1:0] latency_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [lstb_pkg::WORD_W-1:0] sample_count,
  output logic [lstb_pkg::WORD_W-1:0] sum_latency,
  output logic [lstb_pkg::WORD_W-1:0] min_latency,
  output logic [lstb_pkg::WORD_W-1:0] max_latency,
  output logic [lstb_pkg::WORD_W-1:0] avg_latency,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lstb_pkg::CFG_W-1:0]  cfg_data
);
  import lstb_pkg::*;

  logic               q_wr;
  op_t                q_wr_op;
  logic               q_full;
  op_t                q_rd_op;
  logic               q_not_empty;
  logic               q_rd;
  logic [Q_CNT_W-1:0] q_count;
  bk_status_t         bk_st;

  // front: config register and classification
  lstb_front #(.NUM_TRACKERS(NUM_TRACKERS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .tracker_id    (tracker_id),
    .latency_value (latency_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_wr          (q_wr),
    .q_op          (q_wr_op),
    .q_full        (q_full)
  );

  // decoupling queue
  lstb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wr_data   (q_wr_op),
    .full      (q_full),
    .rd        (q_rd),
    .rd_data   (q_rd_op),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  // back: stores, divider, result register
  lstb_back #(.NUM_TRACKERS(NUM_TRACKERS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_not_empty),
    .op           (q_rd_op),
    .op_take      (q_rd),
    .empty        (empty),
    .pop          (pop),
    .sample_count (sample_count),
    .sum_latency  (sum_latency),
    .min_latency  (min_latency),
    .max_latency  (max_latency),
    .avg_latency  (avg_latency),
    .status       (bk_st)
  );

  // a finished quotient is never dropped while the result register is held
  `CHK_NEXT(a_done_held, clk, rst, bk_st.div_done && bk_st.out_valid && !pop, bk_st.div_done)
  // a read is only launched into an idle divider
  `CHK_IMPL(a_start_idle, clk, rst, bk_st.div_start, !bk_st.div_busy)
  // full reflects a queue at capacity
  `CHK_IMPL(a_full_count, clk, rst, full, q_count == Q_CNT_W'(Q_DEPTH))

endmodule

### hdl/lstb_queue.sv
// Small FIFO of classified operations between front and back.
module lstb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr,
  input  lstb_pkg::op_t           wr_data,
  output logic                    full,
  input  logic                    rd,
  output lstb_pkg::op_t           rd_data,
  output logic                    not_empty,
  output logic [lstb_pkg::Q_CNT_W-1:0] count
);
  import lstb_pkg::*;

  op_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic               do_wr;
  logic               do_rd;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/lstb_front.sv
// Front end: config register, id check and command classification.
module lstb_front #(
  parameter int NUM_TRACKERS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [lstb_pkg::CMD_W-1:0]    cmd,
  input  logic [lstb_pkg::ID_W-1:0]     tracker_id,
  input  logic [lstb_pkg::WORD_W-1:0]   latency_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lstb_pkg::CFG_W-1:0]    cfg_data,
  output logic                          q_wr,
  output lstb_pkg::op_t                 q_op,
  input  logic                          q_full
);
  import lstb_pkg::*;

  logic [CFG_W-1:0] trackers_in_use;
  logic             id_ok;
  logic             keep;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      trackers_in_use <= '0;
    end else if (cfg_valid) begin
      trackers_in_use <= cfg_data;
    end
  end

  // id must be below both the registered count and the bank size
  assign id_ok = ({1'b0, tracker_id} < trackers_in_use) &&
                 (32'(tracker_id) < NUM_TRACKERS);

  always_comb begin
    q_op.id     = tracker_id;
    q_op.sample = latency_value;
    q_op.kind   = OP_RECORD;
    keep        = 1'b0;
    unique case (cmd)
      CMD_RECORD: begin
        q_op.kind = OP_RECORD;
        keep      = id_ok;
      end
      CMD_READ: begin
        q_op.kind = id_ok ? OP_READ : OP_READ_ZERO;
        keep      = 1'b1;
      end
      CMD_CLEAR: begin
        q_op.kind = OP_CLEAR;
        keep      = id_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_wr = accept && keep;

endmodule

### hdl/lstb_div.sv
// Radix-2 restoring divider, 64-bit, one quotient bit per cycle.
module lstb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lstb_pkg::WORD_W-1:0] dividend,
  input  logic [lstb_pkg::WORD_W-1:0] divisor,
  input  logic                        ack,
  output logic                        busy,
  output logic                        done,
  output logic [lstb_pkg::WORD_W-1:0] quotient
);
  import lstb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam int STEP_W = $clog2(WORD_W);

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              ge;

  assign rem_sh   = {rem, quo[WORD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge       = !diff[WORD_W+1];
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= (divisor == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (step == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      rem  <= '0;
      quo  <= (divisor == '0) ? '0 : dividend;
      dvs  <= divisor;
      step <= STEP_W'(WORD_W - 1);
    end else if (state == S_RUN) begin
      quo  <= {quo[WORD_W-2:0], ge};
      rem  <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      step <= step - 1'b1;
    end
  end

endmodule

### hdl/lstb_back.sv
// Back end: tracker stores, record/clear updates, read snapshot and result register.
module lstb_back #(
  parameter int NUM_TRACKERS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  input  lstb_pkg::op_t               op,
  output logic                        op_take,
  output logic                        empty,
  input  logic                        pop,
  output logic [lstb_pkg::WORD_W-1:0] sample_count,
  output logic [lstb_pkg::WORD_W-1:0] sum_latency,
  output logic [lstb_pkg::WORD_W-1:0] min_latency,
  output logic [lstb_pkg::WORD_W-1:0] max_latency,
  output logic [lstb_pkg::WORD_W-1:0] avg_latency,
  output lstb_pkg::bk_status_t        status
);
  import lstb_pkg::*;

  localparam int DEPTH = (NUM_TRACKERS < (1 << ID_W)) ? NUM_TRACKERS : (1 << ID_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] cnt_st [DEPTH];
  logic [WORD_W-1:0] sum_st [DEPTH];
  logic [WORD_W-1:0] min_st [DEPTH];
  logic [WORD_W-1:0] max_st [DEPTH];

  logic [IDX_W-1:0]  ix;
  logic [WORD_W-1:0] cur_cnt, cur_sum, cur_min, cur_max;
  logic              is_read;
  logic              div_start, div_busy, div_done, out_load;
  logic [WORD_W-1:0] quotient;
  logic [WORD_W-1:0] snap_cnt, snap_sum, snap_min, snap_max;
  logic [WORD_W-1:0] rd_cnt, rd_sum, rd_min, rd_max;
  logic              out_valid;

  assign ix      = op.id[IDX_W-1:0];
  assign cur_cnt = cnt_st[ix];
  assign cur_sum = sum_st[ix];
  assign cur_min = min_st[ix];
  assign cur_max = max_st[ix];

  assign is_read   = (op.kind == OP_READ) || (op.kind == OP_READ_ZERO);
  assign op_take   = op_valid && (!is_read || !div_busy);
  assign div_start = op_take && is_read;

  // read values; invalid id reads as all zero, unset minimum reads as zero
  always_comb begin
    if (op.kind == OP_READ) begin
      rd_cnt = cur_cnt;
      rd_sum = cur_sum;
      rd_min = (cur_min == '1) ? '0 : cur_min;
      rd_max = cur_max;
    end else begin
      rd_cnt = '0;
      rd_sum = '0;
      rd_min = '0;
      rd_max = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        cnt_st[i] <= '0;
        sum_st[i] <= '0;
        min_st[i] <= '1;
        max_st[i] <= '0;
      end
    end else if (op_take) begin
      if (op.kind == OP_RECORD) begin
        cnt_st[ix] <= cur_cnt + 1'b1;
        sum_st[ix] <= cur_sum + op.sample;
        if (op.sample < cur_min) begin
          min_st[ix] <= op.sample;
        end
        if (op.sample > cur_max) begin
          max_st[ix] <= op.sample;
        end
      end else if (op.kind == OP_CLEAR) begin
        cnt_st[ix] <= '0;
        sum_st[ix] <= '0;
        min_st[ix] <= '1;
        max_st[ix] <= '0;
      end
    end
  end

  // snapshot stays put until the divider is acked
  always_ff @(posedge clk) begin
    if (div_start) begin
      snap_cnt <= rd_cnt;
      snap_sum <= rd_sum;
      snap_min <= rd_min;
      snap_max <= rd_max;
    end
  end

  lstb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_sum),
    .divisor  (rd_cnt),
    .ack      (out_load),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // result register
  assign out_load = div_done && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_count <= snap_cnt;
      sum_latency  <= snap_sum;
      min_latency  <= snap_min;
      max_latency  <= snap_max;
      avg_latency  <= quotient;
    end
  end

  assign status.div_start = div_start;
  assign status.div_busy  = div_busy;
  assign status.div_done  = div_done;
  assign status.out_valid = out_valid;

endmodule

### verif/latency_stats_tracker_bank_top_tb.sv
// Self-checking testbench for the latency statistics tracker bank top level.
module latency_stats_tracker_bank_top_tb;
  import lstb_pkg::*;

  localparam int BANK_SIZE = 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // spare code, block must drop it
  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam int DRAIN_CYCLES = 100;    // drain margin for the read path through the divider
  localparam int SINK_HOLD = 600;       // long back-pressure stretch on the result side
  localparam int IDLE_LIMIT = 3000;     // watchdog: cycles without any transaction
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES = 8;
  localparam int STALL_PHASE = 4;
  localparam int MAX_SHOWN = 10;
  localparam logic [CFG_W-1:0] PHASE_SETTING [NUM_PHASES] =
    '{4'd8, 4'd5, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd0};

  // One read result; cnt sits in the top bits, avg in the bottom ones.
  typedef struct packed {
    logic [WORD_W-1:0] cnt, sum, mn, mx, avg;
  } stats_t;

  // Directed stimulus row: either a register write or one input transaction.
  // For reads whose answer is obvious, the expected stats are typed in.
  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  setting;
    logic [CMD_W-1:0]  op;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] sample;
    bit                typed;
    stats_t            want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              push;
  logic              full;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   tracker_id;
  logic [WORD_W-1:0] latency_value;
  logic              empty;
  logic              pop;
  logic [WORD_W-1:0] sample_count;
  logic [WORD_W-1:0] sum_latency;
  logic [WORD_W-1:0] min_latency;
  logic [WORD_W-1:0] max_latency;
  logic [WORD_W-1:0] avg_latency;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;

  // Shadow copy of the tracker bank and of trackers_in_use.
  logic [WORD_W-1:0] trk_count [BANK_SIZE];
  logic [WORD_W-1:0] trk_sum   [BANK_SIZE];
  logic [WORD_W-1:0] trk_min   [BANK_SIZE];
  logic [WORD_W-1:0] trk_max   [BANK_SIZE];
  logic [CFG_W-1:0]  in_use_reg;

  stats_t    pending_stats [$];   // read results still owed by the block, oldest first
  plan_row_t directed_plan [$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        source_no_gaps = 1'b0;
  bit        sink_no_gaps = 1'b0;
  int        sink_holds_wanted = 0;
  string     field_name [5] = '{"avg_latency", "max_latency", "min_latency", "sum_latency",
                                "sample_count"};

  latency_stats_tracker_bank_top #(
    .NUM_TRACKERS(BANK_SIZE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cmd(cmd),
    .tracker_id(tracker_id),
    .latency_value(latency_value),
    .empty(empty),
    .pop(pop),
    .sample_count(sample_count),
    .sum_latency(sum_latency),
    .min_latency(min_latency),
    .max_latency(max_latency),
    .avg_latency(avg_latency),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void wipe_tracker(input int idx);
    trk_count[idx] = '0;
    trk_sum[idx]   = '0;
    trk_min[idx]   = ALL_ONES;
    trk_max[idx]   = '0;
  endfunction

  // Applies one accepted transaction to the shadow bank. Returns 1 when the
  // transaction yields a result (every read does, valid id or not).
  function automatic bit stats_predict(input logic [CMD_W-1:0] op,
                                       input logic [ID_W-1:0] id,
                                       input logic [WORD_W-1:0] sample,
                                       output stats_t res);
    bit hit;
    hit = (id < in_use_reg) && (int'(id) < BANK_SIZE);
    res = '0;
    case (op)
      CMD_RECORD: begin
        if (hit) begin
          trk_count[id] = trk_count[id] + 1'b1;
          trk_sum[id]   = trk_sum[id] + sample;      // wraps mod 2^64
          if (sample < trk_min[id]) trk_min[id] = sample;
          if (sample > trk_max[id]) trk_max[id] = sample;
        end
      end
      CMD_CLEAR: begin
        if (hit) wipe_tracker(id);
      end
      CMD_READ: begin
        // out-of-range id reads back as all zeros
        if (hit) begin
          res.cnt = trk_count[id];
          res.sum = trk_sum[id];
          res.mn  = (trk_min[id] == ALL_ONES) ? '0 : trk_min[id];
          res.mx  = trk_max[id];
          res.avg = (trk_count[id] != 0) ? trk_sum[id] / trk_count[id] : '0;
        end
        return 1'b1;
      end
      default: ;  // spare code: dropped
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] setting);
    plan_row_t r;
    r = '{is_cfg: 1'b1, setting: setting, op: CMD_RECORD, id: '0, sample: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t op_row(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                                       input logic [WORD_W-1:0] sample);
    plan_row_t r;
    r = '{is_cfg: 1'b0, setting: '0, op: op, id: id, sample: sample,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t read_row(input logic [ID_W-1:0] id, input stats_t want);
    plan_row_t r;
    r = '{is_cfg: 1'b0, setting: '0, op: CMD_READ, id: id, sample: '0,
          typed: 1'b1, want: want};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Tasks are entered and left right after a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one input transaction, waits for full to drop, then books the
  // expected result (typed-in value if given, predictor otherwise).
  task automatic offer(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                       input logic [WORD_W-1:0] sample, input bit typed,
                       input stats_t want);
    int gap;
    stats_t res;
    gap = source_no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd           <= op;
    tracker_id    <= id;
    latency_value <= sample;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    if (stats_predict(op, id, sample, res))
      pending_stats.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Register write: drain all owed results, then give in-flight records and
  // clears time to retire before touching trackers_in_use.
  task automatic write_setting(input logic [CFG_W-1:0] setting);
    push <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data  <= setting;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    in_use_reg = setting;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : source
    logic [CFG_W-1:0]  setting;
    logic [CMD_W-1:0]  op;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] sample;
    int                limit;
    int                read_pct;
    int                pick;

    rst           = 1'b1;
    push          = 1'b0;
    cmd           = CMD_RECORD;
    tracker_id    = '0;
    latency_value = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    for (int i = 0; i < BANK_SIZE; i++) wipe_tracker(i);
    in_use_reg = '0;

    // Directed part: reset state, id validity, extremes, wrap, spare code,
    // clears, register above bank size, and contents kept across a shrink.
    directed_plan.push_back(cfg_row(4'd0));
    directed_plan.push_back(read_row(3'd0, '0));                 // nothing valid yet
    directed_plan.push_back(op_row(CMD_RECORD, 3'd0, 64'd5));     // dropped
    directed_plan.push_back(read_row(3'd0, '0));
    directed_plan.push_back(cfg_row(4'd15));                     // wider than the bank
    directed_plan.push_back(read_row(3'd7, '0));                 // fresh tracker reads 0
    directed_plan.push_back(op_row(CMD_RECORD, 3'd7, ALL_ONES));
    // all-ones min reads back as 0
    directed_plan.push_back(read_row(3'd7, '{cnt: 64'd1, sum: ALL_ONES, mn: '0,
                                             mx: ALL_ONES, avg: ALL_ONES}));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd7, 64'd1));     // sum wraps to 0
    directed_plan.push_back(read_row(3'd7, '{cnt: 64'd2, sum: '0, mn: 64'd1,
                                             mx: ALL_ONES, avg: '0}));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd3, 64'd0));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd3, 64'h8000_0000_0000_0000));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd3, 64'd7));
    directed_plan.push_back(op_row(CMD_READ, 3'd3, '0));
    directed_plan.push_back(op_row(CMD_UNUSED, 3'd3, ALL_ONES)); // spare code dropped
    directed_plan.push_back(op_row(CMD_READ, 3'd3, ALL_ONES));
    directed_plan.push_back(op_row(CMD_CLEAR, 3'd3, '0));
    directed_plan.push_back(read_row(3'd3, '0));
    directed_plan.push_back(cfg_row(4'd2));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd5, 64'd9));     // out of range
    directed_plan.push_back(op_row(CMD_CLEAR, 3'd7, '0));         // out of range
    directed_plan.push_back(read_row(3'd7, '0));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd1, 64'h5555_5555_5555_5555));
    directed_plan.push_back(op_row(CMD_RECORD, 3'd1, 64'hAAAA_AAAA_AAAA_AAAA));
    directed_plan.push_back(cfg_row(4'd8));
    directed_plan.push_back(op_row(CMD_READ, 3'd7, '0));         // contents survived
    directed_plan.push_back(op_row(CMD_READ, 3'd1, '0));
    directed_plan.push_back(op_row(CMD_READ, 3'd0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg)
        write_setting(directed_plan[i].setting);
      else
        offer(directed_plan[i].op, directed_plan[i].id, directed_plan[i].sample,
              directed_plan[i].typed, directed_plan[i].want);
    end

    // Random part: one register setting per phase, each phase drained first.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setting = (ph == NUM_PHASES - 1) ? CFG_W'($urandom_range(0, 15)) : PHASE_SETTING[ph];
      write_setting(setting);
      source_no_gaps = (ph == 1) || (ph == 3) || (ph == STALL_PHASE);
      sink_no_gaps   = (ph == 3);
      read_pct       = (ph == STALL_PHASE) ? 70 : 25;
      // read-heavy burst against a stalled sink: fills the queue, raises full
      if (ph == STALL_PHASE) sink_holds_wanted++;
      limit = (int'(in_use_reg) > BANK_SIZE) ? BANK_SIZE : int'(in_use_reg);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 7)                  op = CMD_UNUSED;
        else if (pick < 15)            op = CMD_CLEAR;
        else if (pick < 15 + read_pct) op = CMD_READ;
        else                           op = CMD_RECORD;

        // mostly valid ids, some out of range
        if (limit != 0 && $urandom_range(0, 9) != 0)
          id = ID_W'($urandom_range(0, limit - 1));
        else
          id = ID_W'($urandom_range(0, BANK_SIZE - 1));

        case ($urandom_range(0, 5))
          0:       sample = '0;
          1:       sample = ALL_ONES;
          2:       sample = {$urandom, $urandom};
          3:       sample = WORD_W'($urandom_range(0, 1000));
          4:       sample = ALL_ONES - WORD_W'($urandom_range(0, 1000));
          default: sample = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase

        offer(op, id, sample, 1'b0, '0);
      end
    end

    // All input accepted. Owed results that never show up trip the watchdog.
    push <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray extra result
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: pops with random gaps, one long hold on request, and checks
  // each result field by field against the oldest owed result.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int     gap;
    int     holds_taken;
    stats_t got;
    stats_t want;

    holds_taken = 0;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_taken < sink_holds_wanted) begin
        holds_taken++;
        pop <= 1'b0;
        for (int k = 0; k < SINK_HOLD; k++) @(negedge clk);
      end
      gap = sink_no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);

      got = '{cnt: sample_count, sum: sum_latency, mn: min_latency, mx: max_latency,
              avg: avg_latency};
      if (pending_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("[%0t] result transaction with nothing owed: cnt=%h sum=%h",
                   $realtime, got.cnt, got.sum);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            for (int k = 0; k < 5; k++)
              if (got[k*WORD_W +: WORD_W] !== want[k*WORD_W +: WORD_W])
                $display("[%0t] %s: expected %h, got %h", $realtime, field_name[k],
                         want[k*WORD_W +: WORD_W], got[k*WORD_W +: WORD_W]);
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: any accepted transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
